/* hw/rtl/dro_pkg.sv */
`timescale 1ns / 1ps
package dro_pkg;

	localparam int TRIG_W = 32;
	localparam int STEP_W = 34;
	localparam int MAG_W = 33;
	localparam int TMAG_W = 29;
	localparam int TABLE_LEN = 24;
	localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd163008219;
	localparam logic signed [TRIG_W-1:0] TRIG_ONE = 32'sd268435456;
	localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};

	typedef enum logic [2:0] {
		REG_LEFT_REVERSE = 3'd0,
		REG_RIGHT_REVERSE = 3'd1,
		REG_DIST_PER_COUNT = 3'd2,
		REG_START_X = 3'd3,
		REG_START_Y = 3'd4
	} cfg_reg_t;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_MUL = 6'b000010,
		S_TRIG = 6'b000100,
		S_MUL2 = 6'b001000,
		S_RND = 6'b010000,
		S_UPD = 6'b100000
	} state_t;

	// arctangent of 2^-i as a 32-bit binary angle
	function automatic logic signed [TRIG_W-1:0] atan_lut(input logic [4:0] i);
		logic signed [TRIG_W-1:0] v;
		unique case (i)
			5'd0: v = 32'sd536870912;
			5'd1: v = 32'sd316933406;
			5'd2: v = 32'sd167458907;
			5'd3: v = 32'sd85004756;
			5'd4: v = 32'sd42667331;
			5'd5: v = 32'sd21354465;
			5'd6: v = 32'sd10679838;
			5'd7: v = 32'sd5340245;
			5'd8: v = 32'sd2670163;
			5'd9: v = 32'sd1335087;
			5'd10: v = 32'sd667544;
			5'd11: v = 32'sd333772;
			5'd12: v = 32'sd166886;
			5'd13: v = 32'sd83443;
			5'd14: v = 32'sd41722;
			5'd15: v = 32'sd20861;
			5'd16: v = 32'sd10430;
			5'd17: v = 32'sd5215;
			5'd18: v = 32'sd2608;
			5'd19: v = 32'sd1304;
			5'd20: v = 32'sd652;
			5'd21: v = 32'sd326;
			5'd22: v = 32'sd163;
			5'd23: v = 32'sd81;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic signed [TRIG_W-1:0] clamp_trig(input logic signed [TRIG_W-1:0] v);
		logic signed [TRIG_W-1:0] r;
		if (v > TRIG_ONE) r = TRIG_ONE;
		else if (v < -TRIG_ONE) r = -TRIG_ONE;
		else r = v;
		return r;
	endfunction

endpackage

/* hw/rtl/dead_reckoning_odometry.sv */
`timescale 1ns / 1ps
// channel  | dir | handshake              | payload
// ---------+-----+------------------------+-----------------------------------------
// s_axis   | in  | s_tvalid / s_tready    | heading, left_count, right_count
// m_axis   | out | m_tvalid / m_tready    | x_pos, y_pos
// cfg      | in  | cfg_valid / cfg_ready  | cfg_index (register number), cfg_data
//
// one request at a time: accept, bit-serial step multiply with the cordic
// running alongside, trig select, bit-serial delta multiply, rounding, update
// the first sample after reset goes to the update and only loads the start position
// a new request is taken while the previous result still waits on m_tready
// the update stalls while the output register is full
// arst_n clears control state and the configuration registers to their defaults
module dead_reckoning_odometry
	import dro_pkg::*;
#(
	parameter int ANGLE_BITS = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// heading [ANGLE_BITS-1:0], left_count, right_count, zero fill to bytes
	input  logic [((ANGLE_BITS+64+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// x_pos [31:0], y_pos [63:32]
	output logic [63:0] m_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int CNT_W = 6;
	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(31);
	localparam logic [CNT_W-1:0] MUL2_LAST = CNT_W'(TMAG_W - 1);
	localparam logic [CNT_W-1:0] CORDIC_N = CNT_W'(CORDIC_STEPS);

	// configuration
	logic left_rev_q, right_rev_q;
	logic [31:0] dpc_q;
	logic signed [31:0] start_x_q, start_y_q;

	// state
	state_t state_q;
	logic [CNT_W-1:0] cnt_q;
	logic started_q, first_q;
	logic [31:0] prev_left_q, prev_right_q;
	logic signed [31:0] pos_x_q, pos_y_q;

	// working registers
	logic [ANGLE_BITS-1:0] head_q;
	logic sneg_q;
	logic [MAG_W-1:0] mag_q;
	logic [65:0] prod1_q;
	logic signed [TRIG_W-1:0] cx_q, cy_q, z_q;
	logic [STEP_W-1:0] step_q;
	logic nx_q, ny_q;
	logic [63:0] px_q, py_q;
	logic [35:0] dx_q, dy_q;
	logic out_valid_q;
	logic [63:0] out_data_q;

	// input unpacking and count deltas
	logic [ANGLE_BITS-1:0] in_head;
	logic [31:0] in_left, in_right, cl, cr, dl, dr;
	logic signed [32:0] sum;
	logic accept, advance;

	assign in_head = s_tdata[ANGLE_BITS-1:0];
	assign in_left = s_tdata[ANGLE_BITS+31:ANGLE_BITS];
	assign in_right = s_tdata[ANGLE_BITS+63:ANGLE_BITS+32];
	assign cl = left_rev_q ? 32'd0 - in_left : in_left;
	assign cr = right_rev_q ? 32'd0 - in_right : in_right;
	assign dl = cl - prev_left_q;
	assign dr = cr - prev_right_q;
	assign sum = {dl[31], dl} + {dr[31], dr};

	assign s_tready = (state_q == S_IDLE);
	assign accept = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	// the result register is free or emptying this cycle
	assign advance = !out_valid_q || m_tready;

	// serial step multiply, one bit of distance_per_count per cycle
	logic [34:0] s1;
	assign s1 = {1'b0, prod1_q[65:32]} + (prod1_q[0] ? {2'b0, mag_q} : 35'd0);

	// cordic rotation, one iteration per cycle
	logic [4:0] it;
	logic signed [TRIG_W-1:0] cdx, cdy, atn;
	assign it = cnt_q[4:0];
	assign cdx = cy_q >>> it;
	assign cdy = cx_q >>> it;
	assign atn = atan_lut(it);

	// quadrant reduction
	logic [1:0] quad;
	logic signed [TRIG_W-1:0] cs_c, sn_c, sin_h, cos_h;
	assign quad = head_q[ANGLE_BITS-1:ANGLE_BITS-2];
	assign cs_c = clamp_trig(cx_q);
	assign sn_c = clamp_trig(cy_q);
	always_comb begin
		unique case (quad)
			2'd0: begin sin_h = sn_c; cos_h = cs_c; end
			2'd1: begin sin_h = cs_c; cos_h = -sn_c; end
			2'd2: begin sin_h = -sn_c; cos_h = -cs_c; end
			default: begin sin_h = -cs_c; cos_h = sn_c; end
		endcase
	end
	logic signed [TRIG_W-1:0] sin_abs, cos_abs;
	assign sin_abs = sin_h[TRIG_W-1] ? -sin_h : sin_h;
	assign cos_abs = cos_h[TRIG_W-1] ? -cos_h : cos_h;

	// step clamp
	logic [STEP_W-1:0] step_c;
	assign step_c = (|prod1_q[65:43]) ? STEP_MAX : prod1_q[42:9];

	// serial delta multiply for both axes, one bit of |trig| per cycle
	logic [35:0] s2x, s2y;
	assign s2x = {1'b0, px_q[63:29]} + (px_q[0] ? {2'b0, step_q} : 36'd0);
	assign s2y = {1'b0, py_q[63:29]} + (py_q[0] ? {2'b0, step_q} : 36'd0);

	// rounding at bit 28
	logic [63:0] rx, ry;
	assign rx = px_q + 64'h0000_0000_0800_0000;
	assign ry = py_q + 64'h0000_0000_0800_0000;

	// position update with saturation
	logic signed [37:0] ux, uy;
	logic signed [31:0] nx_pos, ny_pos;
	assign ux = nx_q ? {{6{pos_x_q[31]}}, pos_x_q} - $signed({2'b0, dx_q})
		: {{6{pos_x_q[31]}}, pos_x_q} + $signed({2'b0, dx_q});
	assign uy = ny_q ? {{6{pos_y_q[31]}}, pos_y_q} - $signed({2'b0, dy_q})
		: {{6{pos_y_q[31]}}, pos_y_q} + $signed({2'b0, dy_q});
	always_comb begin
		priority if (ux > 38'sd2147483647) nx_pos = 32'sh7fffffff;
		else if (ux < -38'sd2147483648) nx_pos = 32'sh80000000;
		else nx_pos = ux[31:0];
		priority if (uy > 38'sd2147483647) ny_pos = 32'sh7fffffff;
		else if (uy < -38'sd2147483648) ny_pos = 32'sh80000000;
		else ny_pos = uy[31:0];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_rev_q <= 1'b0;
			right_rev_q <= 1'b0;
			dpc_q <= 32'd402624;
			start_x_q <= -32'sd1146880;
			start_y_q <= -32'sd1441792;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LEFT_REVERSE: left_rev_q <= cfg_data[0];
				REG_RIGHT_REVERSE: right_rev_q <= cfg_data[0];
				REG_DIST_PER_COUNT: dpc_q <= cfg_data;
				REG_START_X: start_x_q <= cfg_data;
				REG_START_Y: start_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			started_q <= 1'b0;
			first_q <= 1'b0;
			prev_left_q <= '0;
			prev_right_q <= '0;
			pos_x_q <= '0;
			pos_y_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result register: loaded by the update, emptied by the sink
			if (state_q == S_UPD && advance) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						prev_left_q <= cl;
						prev_right_q <= cr;
						started_q <= 1'b1;
						first_q <= !started_q;
						cnt_q <= '0;
						state_q <= started_q ? S_MUL : S_UPD;
					end
				end
				S_MUL: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == MUL_LAST) state_q <= S_TRIG;
				end
				S_TRIG: begin
					cnt_q <= '0;
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == MUL2_LAST) state_q <= S_RND;
				end
				S_RND: state_q <= S_UPD;
				S_UPD: begin
					if (advance) begin
						if (first_q) begin
							pos_x_q <= start_x_q;
							pos_y_q <= start_y_q;
						end else begin
							pos_x_q <= nx_pos;
							pos_y_q <= ny_pos;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			head_q <= in_head;
			sneg_q <= sum[32];
			mag_q <= sum[32] ? MAG_W'(-sum) : MAG_W'(sum);
			prod1_q <= {34'd0, dpc_q};
			cx_q <= CORDIC_GAIN;
			cy_q <= '0;
			// angle within the quadrant, quadrant bits dropped
			z_q <= {2'b00, in_head[ANGLE_BITS-3:0], {(32 - ANGLE_BITS){1'b0}}};
		end
		if (state_q == S_MUL) begin
			prod1_q <= {s1, prod1_q[31:1]};
			if (cnt_q < CORDIC_N) begin
				if (!z_q[TRIG_W-1]) begin
					cx_q <= cx_q - cdx;
					cy_q <= cy_q + cdy;
					z_q <= z_q - atn;
				end else begin
					cx_q <= cx_q + cdx;
					cy_q <= cy_q - cdy;
					z_q <= z_q + atn;
				end
			end
		end
		if (state_q == S_TRIG) begin
			step_q <= step_c;
			nx_q <= sneg_q ^ sin_h[TRIG_W-1];
			ny_q <= sneg_q ^ cos_h[TRIG_W-1];
			px_q <= {35'd0, sin_abs[TMAG_W-1:0]};
			py_q <= {35'd0, cos_abs[TMAG_W-1:0]};
		end
		if (state_q == S_MUL2) begin
			px_q <= {s2x, px_q[28:1]};
			py_q <= {s2y, py_q[28:1]};
		end
		if (state_q == S_RND) begin
			dx_q <= rx[63:28];
			dy_q <= ry[63:28];
		end
		if (state_q == S_UPD && advance) begin
			out_data_q <= first_q ? {start_y_q, start_x_q} : {ny_pos, nx_pos};
		end
	end

	// the first sample goes straight to the update, later ones through the multiply
	a_accept_path: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_MUL) || (state_q == S_UPD))
		else $error("bad path after accept");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL2) |-> (cnt_q <= MUL2_LAST))
		else $error("delta multiply counter overrun");

	a_first_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD && first_q && advance) |=>
		(m_tvalid && m_tdata[31:0] == $past(start_x_q)))
		else $error("first result is not the start position");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready && state_q == S_UPD) |=> (state_q == S_UPD))
		else $error("result overwritten while stalled");

endmodule

/* bench/odometry_checker.sv */
`timescale 1ns / 1ps
module odometry_checker
	import dro_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic s_tready,
	input  logic [79:0] s_tdata,
	input  logic m_tvalid,
	input  logic m_tready,
	input  logic [63:0] m_tdata,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data,
	output int errors,
	output int pending,
	output int poses_seen
);

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
	} pose_t;

	localparam longint TRIG_UNIT = 268435456;
	localparam longint unsigned STEP_CAP = 64'h3_FFFF_FFFF;

	longint atan_tbl [16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
		21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861};

	// shadow of the configuration registers
	bit rev_l, rev_r;
	bit [31:0] dist_q824;
	bit [31:0] home_x, home_y;
	// shadow of the odometry state
	bit started;
	bit [31:0] last_l, last_r;
	longint pos_x, pos_y;

	pose_t pose_q[$];

	assign pending = pose_q.size();

	function automatic longint clamp_unit(input longint v);
		if (v > TRIG_UNIT) return TRIG_UNIT;
		if (v < -TRIG_UNIT) return -TRIG_UNIT;
		return v;
	endfunction

	// move one axis by step*trig, rounded half up, then saturate
	function automatic longint glide(input longint pos, input longint unsigned step,
		input bit neg, input longint trig);
		longint unsigned tmag;
		longint unsigned d;
		longint r;
		bit n;
		n = neg;
		if (trig < 0) begin
			tmag = -trig;
			n = !n;
		end else begin
			tmag = trig;
		end
		d = (step * tmag + 64'd134217728) >> 28;
		r = n ? pos - longint'(d) : pos + longint'(d);
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		return r;
	endfunction

	task automatic track_sample(input bit [15:0] hdg, input bit [31:0] lc, input bit [31:0] rc);
		bit [31:0] cl, cr, dl, dr, ang;
		longint sum, z, cx, cy, dx, dy, sn, cs, sin_h, cos_h;
		longint unsigned mag, step;
		bit sneg;
		pose_t p;
		cl = rev_l ? 32'(0 - lc) : lc;
		cr = rev_r ? 32'(0 - rc) : rc;
		if (!started) begin
			started = 1'b1;
			pos_x = longint'($signed(home_x));
			pos_y = longint'($signed(home_y));
		end else begin
			dl = cl - last_l;
			dr = cr - last_r;
			sum = longint'($signed(dl)) + longint'($signed(dr));
			sneg = sum < 0;
			mag = sneg ? -sum : sum;
			step = (mag * longint'(dist_q824)) >> 9;
			if (step > STEP_CAP) step = STEP_CAP;
			ang = {hdg, 16'h0000};
			z = longint'(ang[29:0]);
			cx = 163008219;
			cy = 0;
			for (int i = 0; i < 16; i++) begin
				dx = cy >>> i;
				dy = cx >>> i;
				if (z >= 0) begin
					cx -= dx; cy += dy; z -= atan_tbl[i];
				end else begin
					cx += dx; cy -= dy; z += atan_tbl[i];
				end
			end
			cs = clamp_unit(cx);
			sn = clamp_unit(cy);
			// quadrant reduction
			case (ang[31:30])
				2'd0: begin sin_h = sn; cos_h = cs; end
				2'd1: begin sin_h = cs; cos_h = -sn; end
				2'd2: begin sin_h = -sn; cos_h = -cs; end
				default: begin sin_h = -cs; cos_h = sn; end
			endcase
			pos_x = glide(pos_x, step, sneg, sin_h);
			pos_y = glide(pos_y, step, sneg, cos_h);
		end
		last_l = cl;
		last_r = cr;
		p.x = pos_x[31:0];
		p.y = pos_y[31:0];
		pose_q.push_back(p);
	endtask

	always @(posedge clk or negedge arst_n) begin
		pose_t want;
		if (!arst_n) begin
			rev_l = 1'b0;
			rev_r = 1'b0;
			dist_q824 = 32'd402624;
			home_x = -32'sd1146880;
			home_y = -32'sd1441792;
			started = 1'b0;
			last_l = '0;
			last_r = '0;
			pos_x = 0;
			pos_y = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_LEFT_REVERSE: rev_l = cfg_data[0];
					REG_RIGHT_REVERSE: rev_r = cfg_data[0];
					REG_DIST_PER_COUNT: dist_q824 = cfg_data;
					REG_START_X: home_x = cfg_data;
					REG_START_Y: home_y = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				track_sample(s_tdata[15:0], s_tdata[47:16], s_tdata[79:48]);
			if (m_tvalid && m_tready) begin
				poses_seen++;
				if (pose_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected pose x=%0d y=%0d", $time,
						$signed(m_tdata[31:0]), $signed(m_tdata[63:32]));
				end else begin
					want = pose_q.pop_front();
					if (m_tdata[31:0] !== want.x) begin
						errors++;
						$display("%0t: x_pos expected %0d actual %0d", $time,
							want.x, $signed(m_tdata[31:0]));
					end
					if (m_tdata[63:32] !== want.y) begin
						errors++;
						$display("%0t: y_pos expected %0d actual %0d", $time,
							want.y, $signed(m_tdata[63:32]));
					end
				end
			end
		end
	end

	initial begin
		errors = 0;
		poses_seen = 0;
	end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
module testbench;
	import dro_pkg::*;

	// cycles without any handshake on the source, sink or configuration port before the run is declared hung
	localparam int HANG_LIMIT = 3000;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [79:0] s_tdata;	// heading [15:0], left_count [47:16], right_count [79:48]
	logic m_tvalid;
	logic m_tready;
	logic [63:0] m_tdata;	// x_pos [31:0], y_pos [63:32]
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	int errors, pending, poses_seen;
	int hang_cnt = 0;
	int sink_hold;
	bit no_idle;
	bit [31:0] enc_l, enc_r;

	dead_reckoning_odometry u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	odometry_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending), .poses_seen(poses_seen)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// result sink: random stall bursts, none in the last phase
	always @(negedge clk) begin
		if (sink_hold > 0) begin
			sink_hold--;
			m_tready = 1'b0;
		end else if (no_idle || $urandom_range(0, 7) != 0) begin
			m_tready = 1'b1;
		end else begin
			sink_hold = $urandom_range(0, 8);
			m_tready = 1'b0;
		end
	end

	// hang watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			hang_cnt <= 0;
		else
			hang_cnt <= hang_cnt + 1;
		if (hang_cnt >= HANG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", HANG_LIMIT);
			$display("testbench failed");
			$finish;
		end
	end

	// register write, only called while the block is idle
	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// wait for every outstanding pose, then let the datapath settle
	task automatic drain();
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// one sample request; optional idle burst ahead of it
	task automatic send_sample(input logic [15:0] hdg, input logic [31:0] lc,
		input logic [31:0] rc);
		int gap;
		@(negedge clk);
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {rc, lc, hdg};
		do @(posedge clk); while (!s_tready);
		enc_l = lc;
		enc_r = rc;
		// drop the request so it is not taken twice
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic apply_setting(input bit rl, input bit rr, input logic [31:0] dpc);
		write_reg(REG_LEFT_REVERSE, {31'd0, rl});
		write_reg(REG_RIGHT_REVERSE, {31'd0, rr});
		write_reg(REG_DIST_PER_COUNT, dpc);
	endtask

	// mostly realistic encoder motion, some wild jumps
	task automatic random_sample();
		logic [31:0] nl, nr;
		logic [15:0] hdg;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 7) begin
			nl = enc_l + 32'($signed($urandom_range(0, 600)) - 300);
			nr = enc_r + 32'($signed($urandom_range(0, 600)) - 300);
		end else if (pick < 9) begin
			nl = enc_l + 32'($signed($urandom_range(0, 200000)) - 100000);
			nr = enc_r + 32'($signed($urandom_range(0, 200000)) - 100000);
		end else begin
			nl = $urandom;
			nr = $urandom;
		end
		if ($urandom_range(0, 9) == 0)
			hdg = 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 2) - 1);
		else
			hdg = 16'($urandom);
		send_sample(hdg, nl, nr);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_LEFT_REVERSE;
		cfg_data = '0;
		sink_hold = 0;
		no_idle = 1'b0;
		enc_l = '0;
		enc_r = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// start pose at the corner of the range
		write_reg(REG_START_X, 32'h8000_0000);
		write_reg(REG_START_Y, 32'h7FFF_FFFF);

		// first sample only places the robot
		send_sample(16'h0000, 32'h7FFF_FFFF, 32'h8000_0000);
		// modular wrap of both counts, all four axis headings
		send_sample(16'h0000, 32'h8000_0010, 32'h7FFF_FFF0);
		send_sample(16'h4000, 32'h8000_0110, 32'h7FFF_FEF0);
		send_sample(16'h8000, 32'h8000_0210, 32'h7FFF_FDF0);
		send_sample(16'hC000, 32'h8000_0310, 32'h7FFF_FCF0);
		send_sample(16'hFFFF, 32'h8000_0410, 32'h7FFF_FBF0);
		send_sample(16'h2000, 32'h8000_0410, 32'h7FFF_FBF0);
		drain();

		// huge steps: step clamp then saturation
		apply_setting(1'b0, 1'b0, 32'hFFFF_FFFF);
		send_sample(16'h2000, 32'h0000_0000, 32'h0000_0000);
		send_sample(16'h2000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_sample(16'hA000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_sample(16'hA000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_sample(16'h6000, 32'h0000_0000, 32'h7FFF_FFFF);
		drain();

		// each encoder reversed on its own, then both
		apply_setting(1'b1, 1'b0, 32'd402624);
		send_sample(16'h1234, 32'd1000, 32'd1000);
		send_sample(16'h1234, 32'd2000, 32'd2000);
		drain();
		apply_setting(1'b0, 1'b1, 32'd402624);
		send_sample(16'hEDCB, 32'd3000, 32'd3000);
		send_sample(16'hEDCB, 32'd4000, 32'd4000);
		drain();
		apply_setting(1'b1, 1'b1, 32'd0);
		send_sample(16'h5555, 32'd9000, 32'd9000);
		send_sample(16'hAAAA, 32'h0, 32'h0);
		drain();

		// random phases over several settings
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: apply_setting(1'b0, 1'b0, 32'd402624);
				1: apply_setting(1'b1, 1'b0, $urandom);
				2: apply_setting(1'b0, 1'b1, 32'h0100_0000);
				3: apply_setting(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					32'hFFFF_FFFF);
				default: begin
					apply_setting(1'b0, 1'b0, 32'd402624);
					write_reg(REG_START_X, $urandom);
					write_reg(REG_START_Y, $urandom);
					no_idle = 1'b1;
				end
			endcase
			for (int k = 0; k < 166; k++) begin
				random_sample();
				// hold the source off until the sink has caught up
				if (k == 80) begin
					@(negedge clk);
					s_tvalid = 1'b0;
					while (pending != 0) @(negedge clk);
				end
			end
			@(negedge clk);
			s_tvalid = 1'b0;
			drain();
		end

		while (pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		$display("covered first-sample placement, count wrap, reversal, step clamp, saturation");
		$display("and random motion over five settings: %0d poses checked", poses_seen);
		if (errors == 0 && pending == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
